>>> sv/dhoat_pkg.sv
// ----------------------------------------------------------------------------
// dhoat_pkg
// Shared widths, operation and status codes and the slot entry layout of the
// double-hashing open-addressing table.
// ----------------------------------------------------------------------------
`default_nettype none

package dhoat_pkg;

    localparam int OP_W       = 2;
    localparam int KEY_HIGH_W = 24;
    localparam int KEY_LOW_W  = 64;
    localparam int KEY_W      = KEY_HIGH_W + KEY_LOW_W;
    localparam int REC_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int LIVE_OUT_W = 5;
    localparam int SUM_W      = 12;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic                  occupied;
        logic                  deleted;
        logic [KEY_HIGH_W-1:0] key_high;
        logic [KEY_LOW_W-1:0]  key_low;
        logic [REC_W-1:0]      record;
    } entry_t;

endpackage

`default_nettype wire

>>> sv/dhoat_hash.sv
// ----------------------------------------------------------------------------
// dhoat_hash
// Sums the key byte codes, then reduces the sum modulo SLOTS and SLOTS-1 by
// reciprocal multiplication: sum, quotient and remainder, each registered in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module dhoat_hash #(
    parameter int SLOTS     = 16,
    parameter int KEY_CHARS = 11
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [dhoat_pkg::KEY_HIGH_W-1:0] key_high,
    input  wire logic [dhoat_pkg::KEY_LOW_W-1:0]  key_low,
    output logic                                  done,
    output logic [$clog2(SLOTS)-1:0]              home,
    output logic [$clog2(SLOTS)-1:0]              step
);
    import dhoat_pkg::*;

    localparam int IW          = $clog2(SLOTS);
    localparam int RECIP_SHIFT = SUM_W + IW;
    localparam int RECIP_W     = SUM_W + 2;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_A =
        RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(SLOTS - 1)) / longint'(SLOTS));
    localparam logic [RECIP_W-1:0] RECIP_B =
        RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(SLOTS - 2)) / longint'(SLOTS - 1));
    localparam logic [SUM_W-1:0] DIV_A = SUM_W'(SLOTS);
    localparam logic [SUM_W-1:0] DIV_B = SUM_W'(SLOTS - 1);

    logic [KEY_W-1:0]  key_all;
    logic [SUM_W-1:0]  byte_sum;

    logic              sum_valid_reg;
    logic              quo_valid_reg;
    logic              done_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  quo_a_reg;
    logic [SUM_W-1:0]  quo_b_reg;
    logic [IW-1:0]     rem_a_reg;
    logic [IW-1:0]     rem_b_reg;

    logic [PROD_W-1:0] prod_a;
    logic [PROD_W-1:0] prod_b;
    logic [PROD_W-1:0] quo_a_wide;
    logic [PROD_W-1:0] quo_b_wide;
    logic [SUM_W-1:0]  back_a;
    logic [SUM_W-1:0]  back_b;
    logic [SUM_W-1:0]  rem_a_full;
    logic [SUM_W-1:0]  rem_b_full;

    assign key_all = {key_high, key_low};

    always_comb
    begin
        byte_sum = '0;
        for (int p = 0; p < KEY_CHARS; p++)
        begin
            byte_sum = byte_sum + SUM_W'(key_all[KEY_W-1-8*p -: 8]);
        end
    end

    assign prod_a     = PROD_W'(sum_reg) * PROD_W'(RECIP_A);
    assign prod_b     = PROD_W'(sum_reg) * PROD_W'(RECIP_B);
    assign quo_a_wide = prod_a >> RECIP_SHIFT;
    assign quo_b_wide = prod_b >> RECIP_SHIFT;
    assign back_a     = quo_a_reg * DIV_A;
    assign back_b     = quo_b_reg * DIV_B;
    assign rem_a_full = sum_reg - back_a;
    assign rem_b_full = sum_reg - back_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            quo_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= start;
            quo_valid_reg <= sum_valid_reg;
            done_reg      <= quo_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sum_reg <= byte_sum;
        end
        if (sum_valid_reg)
        begin
            quo_a_reg <= quo_a_wide[SUM_W-1:0];
            quo_b_reg <= quo_b_wide[SUM_W-1:0];
        end
        if (quo_valid_reg)
        begin
            rem_a_reg <= rem_a_full[IW-1:0];
            rem_b_reg <= rem_b_full[IW-1:0];
        end
    end

    assign done = done_reg;
    assign home = rem_a_reg;
    assign step = rem_b_reg + 1'b1;

endmodule

`default_nettype wire

>>> sv/double_hash_open_address_table.sv
// ----------------------------------------------------------------------------
// double_hash_open_address_table
// Open-addressing hash table with double hashing, keyed by an 11-character
// phone number; insert, search and remove, one result word per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries opcode, key and record index.
//   Output channel (out_valid/out_stall) carries status, found_index,
//   slot_used and live_entries, one word for every input word, in order.
//   After reset the slot memory is cleared, one slot a cycle, until every
//   slot is written; in_stall stays high during that pass.
//   Sequence: the key sum and its two residues are computed first (byte
//   sum, reciprocal multiply, remainder), then each probe reads one slot
//   from memory and then evaluates it. An item makes at most SLOTS probes
//   before its result is ready.
//   Throughput: one item at a time; the next word is taken the cycle after
//   the result is loaded into the output register.
//   A stalled result holds in the output register while the next item is
//   hashed and probed; that item completes once the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module double_hash_open_address_table #(
    parameter int SLOTS     = 16,
    parameter int KEY_CHARS = 11
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [dhoat_pkg::OP_W-1:0]       opcode,
    input  wire logic [dhoat_pkg::KEY_HIGH_W-1:0] key_chars_high,
    input  wire logic [dhoat_pkg::KEY_LOW_W-1:0]  key_chars_low,
    input  wire logic [dhoat_pkg::REC_W-1:0]      record_index,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [dhoat_pkg::STATUS_W-1:0]        status,
    output logic [dhoat_pkg::REC_W-1:0]           found_index,
    output logic [dhoat_pkg::SLOT_OUT_W-1:0]      slot_used,
    output logic [dhoat_pkg::LIVE_OUT_W-1:0]      live_entries
);
    import dhoat_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [KEY_W-1:0] KEY_MASK = ~(KEY_W'(0)) << (KEY_W - 8 * KEY_CHARS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [IW-1:0]         clr_reg;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [IW-1:0]         step_reg;
    logic [IW-1:0]         probe_reg, probe_next;
    logic [CW-1:0]         live_reg, live_next;
    logic [OP_W-1:0]       op_reg;
    logic [KEY_HIGH_W-1:0] key_high_reg;
    logic [KEY_LOW_W-1:0]  key_low_reg;
    logic [REC_W-1:0]      rec_reg;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [REC_W-1:0]      found_reg;
    logic [SLOT_OUT_W-1:0] slot_reg;
    logic [LIVE_OUT_W-1:0] live_out_reg;

    entry_t                mem [SLOTS];
    entry_t                rd_reg;
    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    entry_t                mem_wdata;

    logic                  in_accept;
    logic                  hash_done;
    logic [IW-1:0]         hash_home;
    logic [IW-1:0]         hash_step;

    logic                  out_free;
    logic                  finish;
    logic [STATUS_W-1:0]   res_status;
    logic [REC_W-1:0]      res_found;
    logic                  res_slot_hit;
    logic                  key_match;
    logic                  last_probe;
    logic [IW:0]           idx_sum;
    logic [IW-1:0]         idx_adv;
    logic [IW+SLOT_OUT_W-1:0] slot_wide;
    logic [CW+LIVE_OUT_W-1:0] live_wide;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    dhoat_hash #(
        .SLOTS     (SLOTS),
        .KEY_CHARS (KEY_CHARS)
    ) u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept),
        .key_high (key_chars_high),
        .key_low  (key_chars_low),
        .done     (hash_done),
        .home     (hash_home),
        .step     (hash_step)
    );

    assign key_match  = ((({rd_reg.key_high, rd_reg.key_low} ^ {key_high_reg, key_low_reg})
                         & KEY_MASK) == '0);
    assign last_probe = (probe_reg == IW'(SLOTS - 1));
    assign idx_sum    = {1'b0, idx_reg} + {1'b0, step_reg};
    assign idx_adv    = (idx_sum >= (IW+1)'(SLOTS)) ? IW'(idx_sum - (IW+1)'(SLOTS))
                                                    : idx_sum[IW-1:0];

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        probe_next   = probe_reg;
        live_next    = live_reg;
        finish       = 1'b0;
        res_status   = ST_NOT_FOUND;
        res_found    = '0;
        res_slot_hit = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = rd_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == IW'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    idx_next   = hash_home;
                    probe_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                case (op_reg) inside
                    OP_INSERT:
                    begin
                        if (!rd_reg.occupied || rd_reg.deleted)
                        begin
                            finish             = 1'b1;
                            res_status         = ST_INSERTED;
                            res_slot_hit       = 1'b1;
                            mem_we             = out_free;
                            mem_wdata.occupied = 1'b1;
                            mem_wdata.deleted  = 1'b0;
                            mem_wdata.key_high = key_high_reg;
                            mem_wdata.key_low  = key_low_reg;
                            mem_wdata.record   = rec_reg;
                            live_next          = live_reg + 1'b1;
                        end
                        else if (last_probe)
                        begin
                            finish     = 1'b1;
                            res_status = ST_FULL;
                        end
                    end
                    OP_SEARCH, OP_REMOVE:
                    begin
                        if (!rd_reg.occupied)
                        begin
                            finish = 1'b1;
                        end
                        else if (!rd_reg.deleted && key_match)
                        begin
                            finish       = 1'b1;
                            res_slot_hit = 1'b1;
                            if (op_reg == OP_SEARCH)
                            begin
                                res_status = ST_FOUND;
                                res_found  = rd_reg.record;
                            end
                            else
                            begin
                                res_status        = ST_REMOVED;
                                mem_we            = out_free;
                                mem_wdata.deleted = 1'b1;
                                if (live_reg != '0)
                                begin
                                    live_next = live_reg - 1'b1;
                                end
                            end
                        end
                        else if (last_probe)
                        begin
                            finish = 1'b1;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase

                if (finish)
                begin
                    if (out_free)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        live_next = live_reg;
                    end
                end
                else
                begin
                    idx_next   = idx_adv;
                    probe_next = probe_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign slot_wide = {{SLOT_OUT_W{1'b0}}, (res_slot_hit ? idx_reg : IW'(0))};
    assign live_wide = {{LIVE_OUT_W{1'b0}}, live_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if ((state_reg == S_EVAL) && finish && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        probe_reg <= probe_next;
        if (state_reg == S_HASH)
        begin
            step_reg <= hash_step;
        end
        if (in_accept)
        begin
            op_reg       <= opcode;
            key_high_reg <= key_chars_high;
            key_low_reg  <= key_chars_low;
            rec_reg      <= record_index;
        end
        if ((state_reg == S_EVAL) && finish && out_free)
        begin
            status_reg   <= res_status;
            found_reg    <= res_found;
            slot_reg     <= slot_wide[SLOT_OUT_W-1:0];
            live_out_reg <= live_wide[LIVE_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_index  = found_reg;
    assign slot_used    = slot_reg;
    assign live_entries = live_out_reg;

endmodule

`default_nettype wire

>>> verif/dhoat_checker.sv
// ----------------------------------------------------------------------------
// Double-hash table checker
// Watches both channels of the table, keeps a shadow copy of the slots and
// the live count, predicts one answer per accepted word and compares each
// returned word field by field with the oldest predicted answer.
// ----------------------------------------------------------------------------
module dhoat_checker #(
    parameter int SLOTS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire logic [dhoat_pkg::OP_W-1:0]       opcode,
    input  wire logic [dhoat_pkg::KEY_HIGH_W-1:0] key_chars_high,
    input  wire logic [dhoat_pkg::KEY_LOW_W-1:0]  key_chars_low,
    input  wire logic [dhoat_pkg::REC_W-1:0]      record_index,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic [dhoat_pkg::STATUS_W-1:0]   status,
    input  wire logic [dhoat_pkg::REC_W-1:0]      found_index,
    input  wire logic [dhoat_pkg::SLOT_OUT_W-1:0] slot_used,
    input  wire logic [dhoat_pkg::LIVE_OUT_W-1:0] live_entries,
    output int                                    mismatches,
    output int                                    pending,
    output int                                    words_checked,
    output int                                    found_count,
    output int                                    removed_count,
    output int                                    full_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import dhoat_pkg::*;

    localparam int KEY_BYTES   = 11;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [REC_W-1:0]      found;
        logic [SLOT_OUT_W-1:0] slot;
        logic [LIVE_OUT_W-1:0] live;
    } answer_t;

    entry_t  slot_mem [SLOTS];
    int      live_total;
    answer_t answer_fifo [$];
    int      error_total;
    int      checked_total;
    int      found_total;
    int      removed_total;
    int      full_total;

    assign mismatches    = error_total;
    assign pending       = answer_fifo.size();
    assign words_checked = checked_total;
    assign found_count   = found_total;
    assign removed_count = removed_total;
    assign full_count    = full_total;

    function automatic answer_t apply_table_op(input logic [OP_W-1:0]  op,
                                               input logic [KEY_W-1:0] key,
                                               input logic [REC_W-1:0] rec);
        int      sum;
        int      probe;
        int      stride;
        int      p;
        int      n;
        answer_t a;

        sum = 0;
        for (p = 0; p < KEY_BYTES; p++)
        begin
            sum += int'(key[KEY_W-1-8*p -: 8]);
        end
        probe  = sum % SLOTS;
        stride = (sum % (SLOTS - 1)) + 1;
        a = '{status: ST_NOT_FOUND, found: '0, slot: '0, live: '0};

        case (op) inside
            OP_INSERT:
            begin
                a.status = ST_FULL;
                for (n = 0; n < SLOTS; n++)
                begin
                    if (!slot_mem[probe].occupied || slot_mem[probe].deleted)
                    begin
                        slot_mem[probe] = '{occupied: 1'b1, deleted: 1'b0,
                                            key_high: key[KEY_W-1 -: KEY_HIGH_W],
                                            key_low: key[KEY_LOW_W-1:0],
                                            record: rec};
                        live_total++;
                        a.status = ST_INSERTED;
                        a.slot   = SLOT_OUT_W'(probe);
                        break;
                    end
                    probe = (probe + stride) % SLOTS;
                end
            end
            OP_SEARCH, OP_REMOVE:
            begin
                for (n = 0; n < SLOTS; n++)
                begin
                    if (!slot_mem[probe].occupied)
                        break;
                    if (!slot_mem[probe].deleted &&
                        {slot_mem[probe].key_high, slot_mem[probe].key_low} == key)
                    begin
                        a.slot = SLOT_OUT_W'(probe);
                        if (op == OP_SEARCH)
                        begin
                            a.status = ST_FOUND;
                            a.found  = slot_mem[probe].record;
                        end
                        else
                        begin
                            a.status = ST_REMOVED;
                            slot_mem[probe].deleted = 1'b1;
                            if (live_total > 0)
                                live_total--;
                        end
                        break;
                    end
                    probe = (probe + stride) % SLOTS;
                end
            end
            default:
            begin
            end
        endcase
        a.live = LIVE_OUT_W'(live_total);
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        answer_t got;

        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_mem[i] = '0;
            end
            live_total    = 0;
            answer_fifo.delete();
            error_total   = 0;
            checked_total = 0;
            found_total   = 0;
            removed_total = 0;
            full_total    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{status: status, found: found_index, slot: slot_used,
                        live: live_entries};
                if (answer_fifo.size() == 0)
                begin
                    if (error_total < REPORT_MAX)
                        $display("%0t: unexpected word: status %0d index %h slot %0d live %0d",
                                 $realtime, got.status, got.found, got.slot, got.live);
                    error_total++;
                end
                else
                begin
                    want = answer_fifo.pop_front();
                    checked_total++;
                    if (want.status == ST_FOUND)
                        found_total++;
                    if (want.status == ST_REMOVED)
                        removed_total++;
                    if (want.status == ST_FULL)
                        full_total++;
                    if (got.status != want.status || got.found != want.found ||
                        got.slot != want.slot || got.live != want.live)
                    begin
                        if (error_total < REPORT_MAX)
                        begin
                            $display("%0t: word %0d: expected status %0d index %h slot %0d live %0d",
                                     $realtime, checked_total, want.status, want.found,
                                     want.slot, want.live);
                            $display("%0t: word %0d: got      status %0d index %h slot %0d live %0d",
                                     $realtime, checked_total, got.status, got.found,
                                     got.slot, got.live);
                        end
                        error_total++;
                    end
                end
            end
            if (in_valid && !in_stall)
                answer_fifo.push_back(apply_table_op(opcode,
                                                     {key_chars_high, key_chars_low},
                                                     record_index));
        end
    end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Double-hash table testbench
// Drives insert, search, remove and undefined operations into the table:
// a directed pass over collisions, tombstones, duplicates and the probe
// limit, then random words over a small pool of colliding keys with noise,
// under changing idle and stall patterns and one long output hold.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dhoat_pkg::*;

    localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;
    localparam int POOL_GROUPS  = 6;
    localparam int POOL_SIZE    = 4 * POOL_GROUPS;
    localparam int RANDOM_WORDS = 1230;
    localparam int CHUNK        = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;

    localparam logic [KEY_W-1:0] KEY_ZERO  = '0;
    localparam logic [KEY_W-1:0] KEY_ONES  = '1;
    localparam logic [KEY_W-1:0] KEY_SEVEN = KEY_W'(7);
    localparam logic [KEY_W-1:0] KEY_SEVEN_FIRST = {8'd7, {(KEY_W-8){1'b0}}};

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       opcode         = '0;
    logic [KEY_HIGH_W-1:0] key_chars_high = '0;
    logic [KEY_LOW_W-1:0]  key_chars_low  = '0;
    logic [REC_W-1:0]      record_index   = '0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [REC_W-1:0]      found_index;
    logic [SLOT_OUT_W-1:0] slot_used;
    logic [LIVE_OUT_W-1:0] live_entries;

    int mismatches;
    int pending;
    int words_checked;
    int found_count;
    int removed_count;
    int full_count;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    int   words_sent     = 0;
    int   directed_words = 0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    double_hash_open_address_table uut (.*);

    dhoat_checker u_checker (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [KEY_W-1:0] random_key();
        logic [95:0] wide;

        wide = {$urandom(), $urandom(), $urandom()};
        return wide[KEY_W-1:0];
    endfunction

    task automatic send_word(input logic [OP_W-1:0]  op,
                             input logic [KEY_W-1:0] key,
                             input logic [REC_W-1:0] rec);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        opcode         <= op;
        key_chars_high <= key[KEY_W-1 -: KEY_HIGH_W];
        key_chars_low  <= key[KEY_LOW_W-1:0];
        record_index   <= rec;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    initial
    begin
        int               ins_mix [3];
        int               srch_mix [3];
        int               c;
        int               k;
        int               g;
        int               v;
        int               a;
        int               b;
        int               m;
        int               roll;
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] key;
        logic [7:0]       tmp;
        logic [OP_W-1:0]  op;

        ins_mix  = '{55, 30, 20};
        srch_mix = '{25, 30, 30};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // probe limit on a stride that covers only two slots
        send_word(OP_SEARCH, KEY_SEVEN, 16'h0000);
        send_word(OP_REMOVE, KEY_SEVEN, 16'h0000);
        send_word(OP_UNDEFINED, KEY_SEVEN, 16'hFFFF);
        send_word(OP_INSERT, KEY_SEVEN, 16'h0000);
        send_word(OP_INSERT, KEY_SEVEN, 16'hFFFF);
        send_word(OP_INSERT, KEY_SEVEN, 16'h0001);
        send_word(OP_SEARCH, KEY_SEVEN_FIRST, 16'h0000);
        send_word(OP_SEARCH, KEY_SEVEN, 16'h0000);
        // tombstones: skip on remove, reuse on insert
        send_word(OP_REMOVE, KEY_SEVEN, 16'h0000);
        send_word(OP_REMOVE, KEY_SEVEN, 16'h0000);
        send_word(OP_REMOVE, KEY_SEVEN, 16'h0000);
        send_word(OP_INSERT, KEY_SEVEN_FIRST, 16'hABCD);
        send_word(OP_SEARCH, KEY_SEVEN_FIRST, 16'h0000);
        send_word(OP_SEARCH, KEY_SEVEN, 16'h0000);
        // field extremes
        send_word(OP_INSERT, KEY_ZERO, 16'h1234);
        send_word(OP_INSERT, KEY_ONES, 16'hFFFF);
        send_word(OP_SEARCH, KEY_ONES, 16'h0000);
        send_word(OP_SEARCH, KEY_ZERO, 16'hFFFF);
        send_word(OP_UNDEFINED, KEY_ONES, 16'h0000);
        send_word(OP_REMOVE, KEY_ZERO, 16'h5555);
        directed_words = words_sent;

        // groups of byte permutations share a sum, hence home slot and stride
        for (g = 0; g < POOL_GROUPS; g++)
        begin
            base = random_key();
            for (v = 0; v < 4; v++)
            begin
                key_pool[4*g+v] = base;
                repeat (3)
                begin
                    a = $urandom_range(0, 10);
                    b = $urandom_range(0, 10);
                    tmp = base[KEY_W-1-8*a -: 8];
                    base[KEY_W-1-8*a -: 8] = base[KEY_W-1-8*b -: 8];
                    base[KEY_W-1-8*b -: 8] = tmp;
                end
            end
        end

        for (c = 0; c * CHUNK < RANDOM_WORDS; c++)
        begin
            case (c % 5)
                1:
                begin
                    send_idle_pct  = 53;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 53;
                end
                3:
                begin
                    send_idle_pct  = 6;
                    recv_stall_pct = 6;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            m = c % 3;
            if (c == 2)
                hold_req <= 1'b1;
            for (k = 0; k < CHUNK && c * CHUNK + k < RANDOM_WORDS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    op = OP_UNDEFINED;
                else if (roll < 3 + ins_mix[m])
                    op = OP_INSERT;
                else if (roll < 3 + ins_mix[m] + srch_mix[m])
                    op = OP_SEARCH;
                else
                    op = OP_REMOVE;
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                if (op != OP_INSERT && $urandom_range(0, 99) < 10)
                    key = random_key();
                send_word(op, key, REC_W'($urandom()));
                if (hold_req)
                    hold_req <= 1'b0;
            end
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words (%0d directed), %0d results compared.",
                 words_sent, directed_words, words_checked);
        $display("Answers: %0d found, %0d removed, %0d table full; one %0d-cycle output hold.",
                 found_count, removed_count, full_count, HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
sv/dhoat_pkg.sv
sv/dhoat_hash.sv
sv/double_hash_open_address_table.sv
verif/dhoat_checker.sv
verif/testbench.sv
